### hw/rtl/rbsc_pkg.sv
package rbsc_pkg;

	localparam int unsigned NODES_MONITORED = 3;
	localparam int unsigned CNT_W = $clog2(NODES_MONITORED + 1);

	localparam logic [2:0] ASP_UNKNOWN = 3'd0;
	localparam logic [2:0] ASP_RED     = 3'd1;
	localparam logic [2:0] ASP_YELLOW  = 3'd2;
	localparam logic [2:0] ASP_DYELLOW = 3'd3;
	localparam logic [2:0] ASP_GREEN   = 3'd4;

	localparam logic OP_AXLE = 1'b0;
	localparam logic OP_PKT  = 1'b1;

	typedef enum logic [1:0] {
		DIR_NONE   = 2'd0,
		DIR_LOWER  = 2'd1,
		DIR_HIGHER = 2'd2
	} dir_t;

	typedef enum logic [0:0] {
		REG_NODE_NUMBER = 1'b0,
		REG_TOTAL_NODES = 1'b1
	} cfg_reg_t;

	typedef logic [2:0][7:0] asp_arr_t;

endpackage

### hw/rtl/rail_block_signal_controller_top.sv
// A request accepted into the input register moves on into the result register,
// which drives the outputs, once that register is empty or its result is taken.
// Throughput: one request per cycle while out_ready is high. While a result waits,
// the input register holds one more request; in_ready drops until the result is taken.
// Reset (arst_n low, asynchronous): both stages empty, aspect green, direction
// none, counters and neighbor aspects zero, node 1 of 2, partner node 2.
module rail_block_signal_controller_top
	import rbsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic       sensor_low,
	input  logic [7:0] pkt_src,
	input  logic [7:0] pkt_dst,
	input  logic [7:0] pkt_axles,
	input  logic [7:0] pkt_byte4,
	input  logic [7:0] pkt_byte5,
	input  logic [7:0] pkt_byte6,
	input  logic [7:0] pkt_byte7,
	input  logic [7:0] pkt_byte8,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       accepted,
	output logic       ready_res,
	output logic [2:0] aspect,
	output logic [7:0] tx_partner,
	output logic [7:0] tx_axles,
	output logic [7:0] tx_prev2,
	output logic [7:0] tx_prev1,
	output logic [7:0] tx_prev0,
	output logic [2:0] tx_own,
	output logic [7:0] tx_next0,
	output logic [7:0] tx_next1,
	output logic [7:0] tx_next2
);

	// Input stage.
	logic       valid_s1;
	logic       op_s1;
	logic       sensor_s1;
	logic [7:0] src_s1, dst_s1, axles_s1;
	logic [7:0] b4_s1, b5_s1, b6_s1, b7_s1, b8_s1;

	// Result stage.
	logic       valid_s2;
	logic       accepted_s2, ready_s2;
	logic [2:0] aspect_s2, own_s2;
	logic [7:0] partner_s2, axles_s2;
	logic [7:0] prev2_s2, prev1_s2, prev0_s2, next0_s2, next1_s2, next2_s2;

	// Node state.
	logic [7:0] node_q, total_q, partner_q;
	logic [2:0] aspect_q;
	dir_t       dir_q;
	logic [7:0] axle_q, next_cnt_q, prev_cnt_q;
	asp_arr_t   next_asp_q, prev_asp_q;
	logic       ready_q;

	// Next-state and result values.
	logic [2:0] aspect_d;
	dir_t       dir_d;
	logic [7:0] axle_d, next_cnt_d, prev_cnt_d, partner_d;
	asp_arr_t   next_asp_d, prev_asp_d;
	logic       ready_d;
	logic       acc_d;
	logic [7:0] tx_partner_d, tx_axles_d;
	logic [7:0] tx_prev2_d, tx_prev1_d, tx_prev0_d, tx_next0_d, tx_next1_d, tx_next2_d;
	logic [2:0] tx_own_d;

	logic       advance;
	logic       has_next, has_prev, pkt_ok, present;
	logic [7:0] next_num, prev_num, cnt_inc, n_axles, n_sig;
	logic [8:0] diff;
	logic [CNT_W-1:0] before_cnt, after_cnt;

	logic [7:0] cfg_node, cfg_total;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign has_next = node_q != total_q;
	assign has_prev = (node_q == total_q) || (node_q != 8'd1);
	assign next_num = node_q + 8'd1;
	assign prev_num = node_q - 8'd1;
	assign pkt_ok   = (op_s1 == OP_PKT) && (src_s1 == partner_q) && (dst_s1 == node_q);
	assign cnt_inc  = axle_q + {7'd0, sensor_s1};

	// Monitored neighbor counts, clamped to the window size.
	assign diff = {1'b0, total_q} - {1'b0, node_q};

	always_comb begin
		if (node_q == 8'd0) begin
			before_cnt = '0;
		end else if ({1'b0, node_q} > 9'(NODES_MONITORED)) begin
			before_cnt = CNT_W'(NODES_MONITORED);
		end else begin
			before_cnt = CNT_W'(node_q - 8'd1);
		end
		if (diff[8] || diff == 9'd0) begin
			after_cnt = '0;
		end else if (diff >= 9'(NODES_MONITORED)) begin
			after_cnt = CNT_W'(NODES_MONITORED);
		end else begin
			after_cnt = CNT_W'(diff);
		end
	end

	always_comb begin
		aspect_d     = aspect_q;
		dir_d        = dir_q;
		axle_d       = axle_q;
		next_cnt_d   = next_cnt_q;
		prev_cnt_d   = prev_cnt_q;
		next_asp_d   = next_asp_q;
		prev_asp_d   = prev_asp_q;
		partner_d    = partner_q;
		ready_d      = ready_q;
		acc_d        = 1'b0;
		tx_partner_d = '0;
		tx_axles_d   = '0;
		tx_prev2_d   = '0;
		tx_prev1_d   = '0;
		tx_prev0_d   = '0;
		tx_own_d     = '0;
		tx_next0_d   = '0;
		tx_next1_d   = '0;
		tx_next2_d   = '0;
		present      = 1'b0;
		n_axles      = '0;
		n_sig        = '0;

		if (op_s1 == OP_AXLE) begin
			axle_d = cnt_inc;
			if (aspect_q != ASP_RED) begin
				aspect_d = ASP_RED;
				priority if (node_q == 8'd1) begin
					// A lone node has nobody to compare against and keeps its direction.
					if (has_next) begin
						if (next_cnt_q > cnt_inc) begin
							dir_d = DIR_LOWER;
						end else if (next_cnt_q < cnt_inc) begin
							dir_d = DIR_HIGHER;
						end else begin
							dir_d = DIR_NONE;
						end
					end
				end else if (node_q == total_q) begin
					if (prev_cnt_q > cnt_inc) begin
						dir_d = DIR_HIGHER;
					end else if (prev_cnt_q < cnt_inc) begin
						dir_d = DIR_LOWER;
					end else begin
						dir_d = DIR_NONE;
					end
				end else begin
					if (prev_cnt_q > cnt_inc && next_cnt_q < cnt_inc) begin
						dir_d = DIR_HIGHER;
					end else if (prev_cnt_q < cnt_inc && next_cnt_q > cnt_inc) begin
						dir_d = DIR_LOWER;
					end else begin
						dir_d = DIR_NONE;
					end
				end
			end
		end else if (pkt_ok) begin
			if (has_next && partner_q == next_num) begin
				next_cnt_d = axles_s1;
				next_asp_d = {b8_s1, b7_s1, b6_s1};
			end else if (has_prev && partner_q == prev_num) begin
				prev_cnt_d = axles_s1;
				prev_asp_d = {b4_s1, b5_s1, b6_s1};
			end

			ready_d = 1'b1;
			for (int i = 0; i < NODES_MONITORED; i++) begin
				if (CNT_W'(i) < before_cnt && (!has_prev || prev_asp_d[i] == 8'd0)) begin
					ready_d = 1'b0;
				end
				if (CNT_W'(i) < after_cnt && (!has_next || next_asp_d[i] == 8'd0)) begin
					ready_d = 1'b0;
				end
			end

			acc_d        = 1'b1;
			tx_partner_d = partner_q;
			tx_axles_d   = axle_q;
			tx_own_d     = aspect_q;
			if (has_prev) begin
				tx_prev2_d = prev_asp_d[2];
				tx_prev1_d = prev_asp_d[1];
				tx_prev0_d = prev_asp_d[0];
			end
			if (has_next) begin
				tx_next0_d = next_asp_d[0];
				tx_next1_d = next_asp_d[1];
				tx_next2_d = next_asp_d[2];
			end

			// Middle nodes talk to both neighbors in turn.
			if (node_q > 8'd1 && node_q < total_q) begin
				partner_d = (partner_q == next_num) ? prev_num : next_num;
			end

			if (ready_d && (dir_q == DIR_HIGHER || dir_q == DIR_LOWER)) begin
				present = (dir_q == DIR_HIGHER) ? has_next : has_prev;
				n_axles = (dir_q == DIR_HIGHER) ? next_cnt_d : prev_cnt_d;
				n_sig   = (dir_q == DIR_HIGHER) ? next_asp_d[0] : prev_asp_d[0];
				if (aspect_q == ASP_GREEN) begin
					dir_d = DIR_NONE;
				end else if (present) begin
					if (aspect_q == ASP_RED) begin
						if (axle_q == n_axles) begin
							aspect_d = ASP_YELLOW;
							axle_d   = '0;
						end
					end else if (aspect_q == ASP_YELLOW) begin
						if (n_sig == {5'd0, ASP_YELLOW}) begin
							aspect_d = ASP_DYELLOW;
						end
					end else if (aspect_q == ASP_DYELLOW) begin
						if (n_sig == {5'd0, ASP_DYELLOW}) begin
							aspect_d = ASP_GREEN;
						end
					end
				end
			end
		end
	end

	// Register values after a configuration write, used to re-derive the partner.
	always_comb begin
		cfg_node  = node_q;
		cfg_total = total_q;
		unique case (cfg_reg_t'(cfg_index))
			REG_NODE_NUMBER: cfg_node  = cfg_data;
			REG_TOTAL_NODES: cfg_total = cfg_data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= operation;
			sensor_s1 <= sensor_low;
			src_s1    <= pkt_src;
			dst_s1    <= pkt_dst;
			axles_s1  <= pkt_axles;
			b4_s1     <= pkt_byte4;
			b5_s1     <= pkt_byte5;
			b6_s1     <= pkt_byte6;
			b7_s1     <= pkt_byte7;
			b8_s1     <= pkt_byte8;
		end
		if (advance) begin
			accepted_s2 <= acc_d;
			ready_s2    <= ready_d;
			aspect_s2   <= aspect_d;
			partner_s2  <= tx_partner_d;
			axles_s2    <= tx_axles_d;
			prev2_s2    <= tx_prev2_d;
			prev1_s2    <= tx_prev1_d;
			prev0_s2    <= tx_prev0_d;
			own_s2      <= tx_own_d;
			next0_s2    <= tx_next0_d;
			next1_s2    <= tx_next1_d;
			next2_s2    <= tx_next2_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q     <= 8'd1;
			total_q    <= 8'd2;
			partner_q  <= 8'd2;
			aspect_q   <= ASP_GREEN;
			dir_q      <= DIR_NONE;
			axle_q     <= '0;
			next_cnt_q <= '0;
			prev_cnt_q <= '0;
			next_asp_q <= '0;
			prev_asp_q <= '0;
			ready_q    <= 1'b0;
		end else begin
			if (advance) begin
				aspect_q   <= aspect_d;
				dir_q      <= dir_d;
				axle_q     <= axle_d;
				next_cnt_q <= next_cnt_d;
				prev_cnt_q <= prev_cnt_d;
				next_asp_q <= next_asp_d;
				prev_asp_q <= prev_asp_d;
				ready_q    <= ready_d;
			end
			if (cfg_we) begin
				node_q    <= cfg_node;
				total_q   <= cfg_total;
				partner_q <= (cfg_node != cfg_total) ? cfg_node + 8'd1 : cfg_node - 8'd1;
			end else if (advance) begin
				partner_q <= partner_d;
			end
		end
	end

	assign out_valid  = valid_s2;
	assign accepted   = accepted_s2;
	assign ready_res  = ready_s2;
	assign aspect     = aspect_s2;
	assign tx_partner = partner_s2;
	assign tx_axles   = axles_s2;
	assign tx_prev2   = prev2_s2;
	assign tx_prev1   = prev1_s2;
	assign tx_prev0   = prev0_s2;
	assign tx_own     = own_s2;
	assign tx_next0   = next0_s2;
	assign tx_next1   = next1_s2;
	assign tx_next2   = next2_s2;

`ifndef SYNTHESIS
	a_aspect_range: assert property (@(posedge clk) disable iff (!arst_n)
		aspect_q >= ASP_RED && aspect_q <= ASP_GREEN)
		else $error("aspect state left the red to green range");

	a_axle_forces_red: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_AXLE |=> aspect_q == ASP_RED)
		else $error("axle request did not force the aspect to red");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !accepted_s2 |-> partner_s2 == 8'd0 && axles_s2 == 8'd0 && own_s2 == 3'd0)
		else $error("non-reply result carries reply bytes");

	a_partner_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !pkt_ok && !cfg_we |=> $stable(partner_q))
		else $error("partner changed without an accepted packet");
`endif

endmodule

### bench/rail_block_signal_controller_top_tb.sv
`timescale 1ns / 1ps

module rail_block_signal_controller_top_tb;
	import rbsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       op;
		logic       sensor_low;
		logic [7:0] src;
		logic [7:0] dst;
		logic [7:0] axles;
		logic [7:0] b4;
		logic [7:0] b5;
		logic [7:0] b6;
		logic [7:0] b7;
		logic [7:0] b8;
	} signal_request_t;

	typedef struct packed {
		logic       accepted;
		logic       ready;
		logic [2:0] aspect;
		logic [7:0] partner;
		logic [7:0] axles;
		logic [7:0] prev2;
		logic [7:0] prev1;
		logic [7:0] prev0;
		logic [2:0] own;
		logic [7:0] next0;
		logic [7:0] next1;
		logic [7:0] next2;
	} signal_reply_t;

	typedef struct packed {
		logic [7:0] node;
		logic [7:0] total;
		logic [2:0] aspect;
		dir_t       dir;
		logic [7:0] tally;
		logic [7:0] partner;
		logic [7:0] next_axles;
		logic [7:0] prev_axles;
		asp_arr_t   next_asp;
		asp_arr_t   prev_asp;
		logic       ready;
	} signal_state_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       operation = 1'b0;
	logic       sensor_low = 1'b0;
	logic [7:0] pkt_src = '0;
	logic [7:0] pkt_dst = '0;
	logic [7:0] pkt_axles = '0;
	logic [7:0] pkt_byte4 = '0;
	logic [7:0] pkt_byte5 = '0;
	logic [7:0] pkt_byte6 = '0;
	logic [7:0] pkt_byte7 = '0;
	logic [7:0] pkt_byte8 = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       accepted;
	logic       ready_res;
	logic [2:0] aspect;
	logic [7:0] tx_partner;
	logic [7:0] tx_axles;
	logic [7:0] tx_prev2;
	logic [7:0] tx_prev1;
	logic [7:0] tx_prev0;
	logic [2:0] tx_own;
	logic [7:0] tx_next0;
	logic [7:0] tx_next1;
	logic [7:0] tx_next2;

	signal_request_t pending_requests[$];
	signal_reply_t   expected_replies[$];
	signal_request_t req_cur;
	signal_reply_t   reply_due;
	signal_state_t   line_state;
	signal_state_t   plan_state;
	bit              req_busy = 1'b0;
	int              gap_left = 0;
	int              stall_left = 0;
	int              idle_pct = 0;
	int              error_count = 0;
	int              cycle_count = 0;

	rail_block_signal_controller_top uut (.*);

	always #6 clk = ~clk;

	function automatic void write_reg(inout signal_state_t s, input cfg_reg_t idx,
			input logic [7:0] val);
		if (idx == REG_NODE_NUMBER) s.node = val;
		else s.total = val;
		s.partner = (s.node != s.total) ? s.node + 8'd1 : s.node - 8'd1;
	endfunction

	// Works out the reply to one request and moves the signal state on.
	function automatic signal_reply_t apply_event(inout signal_state_t s,
			input signal_request_t rq);
		signal_reply_t rp;
		logic [7:0] up_id, down_id, nb_axles, nb_asp;
		logic up_ok, down_ok, toward_higher;
		int lower_cnt, upper_cnt;
		rp = '0;
		up_id = s.node + 8'd1;
		down_id = s.node - 8'd1;
		up_ok = s.node != s.total;
		down_ok = s.node == s.total || s.node != 8'd1;
		if (rq.op == OP_AXLE) begin
			if (rq.sensor_low) s.tally = s.tally + 8'd1;
			if (s.aspect != ASP_RED) begin
				s.aspect = ASP_RED;
				if (s.node == 8'd1) begin
					// A lone node has nobody to compare with, so the direction holds.
					if (up_ok) begin
						if (s.next_axles > s.tally) s.dir = DIR_LOWER;
						else if (s.next_axles < s.tally) s.dir = DIR_HIGHER;
						else s.dir = DIR_NONE;
					end
				end else if (s.node == s.total) begin
					if (s.prev_axles > s.tally) s.dir = DIR_HIGHER;
					else if (s.prev_axles < s.tally) s.dir = DIR_LOWER;
					else s.dir = DIR_NONE;
				end else if (s.prev_axles > s.tally && s.next_axles < s.tally) begin
					s.dir = DIR_HIGHER;
				end else if (s.prev_axles < s.tally && s.next_axles > s.tally) begin
					s.dir = DIR_LOWER;
				end else begin
					s.dir = DIR_NONE;
				end
			end
		end else if (rq.src == s.partner && rq.dst == s.node) begin
			if (up_ok && s.partner == up_id) begin
				s.next_axles = rq.axles;
				s.next_asp[0] = rq.b6;
				s.next_asp[1] = rq.b7;
				s.next_asp[2] = rq.b8;
			end else if (down_ok && s.partner == down_id) begin
				s.prev_axles = rq.axles;
				s.prev_asp[0] = rq.b6;
				s.prev_asp[1] = rq.b5;
				s.prev_asp[2] = rq.b4;
			end
			lower_cnt = int'(s.node) - 1;
			upper_cnt = int'(s.total) - int'(s.node);
			s.ready = 1'b1;
			for (int i = 0; i < NODES_MONITORED; i++) begin
				if (i < lower_cnt && (!down_ok || s.prev_asp[i] == 8'd0)) s.ready = 1'b0;
				if (i < upper_cnt && (!up_ok || s.next_asp[i] == 8'd0)) s.ready = 1'b0;
			end
			rp.accepted = 1'b1;
			rp.partner = s.partner;
			rp.axles = s.tally;
			if (down_ok) begin
				rp.prev2 = s.prev_asp[2];
				rp.prev1 = s.prev_asp[1];
				rp.prev0 = s.prev_asp[0];
			end
			rp.own = s.aspect;
			if (up_ok) begin
				rp.next0 = s.next_asp[0];
				rp.next1 = s.next_asp[1];
				rp.next2 = s.next_asp[2];
			end
			if (s.node > 8'd1 && s.node < s.total)
				s.partner = (s.partner == up_id) ? down_id : up_id;
			if (s.ready && (s.dir == DIR_HIGHER || s.dir == DIR_LOWER)) begin
				if (s.aspect == ASP_GREEN) begin
					s.dir = DIR_NONE;
				end else begin
					toward_higher = s.dir == DIR_HIGHER;
					nb_axles = toward_higher ? s.next_axles : s.prev_axles;
					nb_asp = toward_higher ? s.next_asp[0] : s.prev_asp[0];
					// With no neighbor on the side of travel the aspect holds.
					if (toward_higher ? up_ok : down_ok) begin
						if (s.aspect == ASP_RED && s.tally == nb_axles) begin
							s.aspect = ASP_YELLOW;
							s.tally = '0;
						end else if (s.aspect == ASP_YELLOW && nb_asp == 8'(ASP_YELLOW)) begin
							s.aspect = ASP_DYELLOW;
						end else if (s.aspect == ASP_DYELLOW && nb_asp == 8'(ASP_DYELLOW)) begin
							s.aspect = ASP_GREEN;
						end
					end
				end
			end
		end
		rp.ready = s.ready;
		rp.aspect = s.aspect;
		return rp;
	endfunction

	function automatic signal_request_t axle_req(input logic low);
		signal_request_t rq;
		rq = '0;
		rq.op = OP_AXLE;
		rq.sensor_low = low;
		return rq;
	endfunction

	function automatic signal_request_t pkt_req(input logic [7:0] src, input logic [7:0] dst,
			input logic [7:0] axles, input logic [7:0] b4, input logic [7:0] b5,
			input logic [7:0] b6, input logic [7:0] b7, input logic [7:0] b8);
		signal_request_t rq;
		rq = '{op: OP_PKT, sensor_low: 1'b0, src: src, dst: dst, axles: axles,
			b4: b4, b5: b5, b6: b6, b7: b7, b8: b8};
		return rq;
	endfunction

	function automatic logic [7:0] aspect_byte();
		int roll;
		roll = $urandom_range(9);
		if (roll < 8) return 8'($urandom_range(1, 4));
		if (roll == 8) return 8'd0;
		return 8'($urandom);
	endfunction

	// Most packets come from the current partner so that the aspect sequence gets
	// exercised. When steering, an axle event that would turn the node red with no
	// known direction is avoided, since such a node never clears again.
	function automatic signal_request_t plan_request(input int axle_pct, input bit steer);
		signal_request_t rq;
		signal_state_t trial;
		int pick;
		rq = '0;
		for (int attempt = 0; attempt < 4; attempt++) begin
			pick = $urandom_range(99);
			rq.sensor_low = 1'($urandom);
			rq.src = 8'($urandom);
			rq.dst = 8'($urandom);
			rq.axles = 8'($urandom);
			rq.b4 = 8'($urandom);
			rq.b5 = 8'($urandom);
			rq.b6 = 8'($urandom);
			rq.b7 = 8'($urandom);
			rq.b8 = 8'($urandom);
			if (attempt < 3 && pick < axle_pct) begin
				rq.op = OP_AXLE;
			end else begin
				rq.op = OP_PKT;
				if (pick % 10 != 0) begin
					rq.src = plan_state.partner;
					rq.dst = plan_state.node;
					case ($urandom_range(3))
						0: ;
						1: rq.axles = 8'($urandom_range(7));
						default: rq.axles = plan_state.tally;
					endcase
					rq.b4 = aspect_byte();
					rq.b5 = aspect_byte();
					rq.b6 = aspect_byte();
					rq.b7 = aspect_byte();
					rq.b8 = aspect_byte();
				end else begin
					case ($urandom_range(2))
						0: rq.src = plan_state.partner;
						1: rq.dst = plan_state.node;
						default: ;
					endcase
				end
			end
			trial = plan_state;
			void'(apply_event(trial, rq));
			if (!steer || plan_state.aspect == ASP_RED || trial.aspect != ASP_RED ||
					trial.dir != DIR_NONE)
				break;
		end
		return rq;
	endfunction

	task automatic queue_request(input signal_request_t rq);
		void'(apply_event(plan_state, rq));
		pending_requests.push_back(rq);
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || req_busy || expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] node, input logic [7:0] total, input int idle,
			input int axle_pct, input int count, input bit steer);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_NODE_NUMBER;
		cfg_data <= node;
		@(posedge clk);
		cfg_index <= REG_TOTAL_NODES;
		cfg_data <= total;
		@(posedge clk);
		cfg_we <= 1'b0;
		write_reg(line_state, REG_NODE_NUMBER, node);
		write_reg(line_state, REG_TOTAL_NODES, total);
		write_reg(plan_state, REG_NODE_NUMBER, node);
		write_reg(plan_state, REG_TOTAL_NODES, total);
		idle_pct = idle;
		repeat (count) queue_request(plan_request(axle_pct, steer));
		wait_drained();
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_busy = 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_replies.push_back(apply_event(line_state, req_cur));
				req_busy = 1'b0;
			end
			if (!req_busy) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if ($urandom_range(99) < idle_pct) begin
					gap_left = $urandom_range(13);
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					req_cur = pending_requests.pop_front();
					req_busy = 1'b1;
					in_valid <= 1'b1;
					operation <= req_cur.op;
					sensor_low <= req_cur.sensor_low;
					pkt_src <= req_cur.src;
					pkt_dst <= req_cur.dst;
					pkt_axles <= req_cur.axles;
					pkt_byte4 <= req_cur.b4;
					pkt_byte5 <= req_cur.b5;
					pkt_byte6 <= req_cur.b6;
					pkt_byte7 <= req_cur.b7;
					pkt_byte8 <= req_cur.b8;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$error("reply arrived with no request outstanding");
					error_count++;
				end else begin
					reply_due = expected_replies.pop_front();
					check_field("accepted", 8'(reply_due.accepted), 8'(accepted));
					check_field("ready_res", 8'(reply_due.ready), 8'(ready_res));
					check_field("aspect", 8'(reply_due.aspect), 8'(aspect));
					check_field("tx_partner", reply_due.partner, tx_partner);
					check_field("tx_axles", reply_due.axles, tx_axles);
					check_field("tx_prev2", reply_due.prev2, tx_prev2);
					check_field("tx_prev1", reply_due.prev1, tx_prev1);
					check_field("tx_prev0", reply_due.prev0, tx_prev0);
					check_field("tx_own", 8'(reply_due.own), 8'(tx_own));
					check_field("tx_next0", reply_due.next0, tx_next0);
					check_field("tx_next1", reply_due.next1, tx_next1);
					check_field("tx_next2", reply_due.next2, tx_next2);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(99) < idle_pct) begin
				stall_left = $urandom_range(13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		line_state = '0;
		line_state.node = 8'd1;
		line_state.total = 8'd2;
		line_state.aspect = ASP_GREEN;
		line_state.dir = DIR_NONE;
		line_state.partner = 8'd2;
		plan_state = line_state;
		idle_pct = 20;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Node 1 of 2 straight out of reset, partner is node 2.
		queue_request(pkt_req(8'd2, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		queue_request(axle_req(1'b1));
		queue_request(axle_req(1'b0));
		queue_request(pkt_req(8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1));
		queue_request(pkt_req(8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1));
		// Red to yellow on equal axle counts, then on up to green.
		queue_request(pkt_req(8'd2, 8'd1, 8'd1, 8'd255, 8'd255, 8'd2, 8'd255, 8'd0));
		queue_request(pkt_req(8'd2, 8'd1, 8'd0, 8'd0, 8'd0, 8'd2, 8'd1, 8'd1));
		queue_request(pkt_req(8'd2, 8'd1, 8'd0, 8'd0, 8'd0, 8'd3, 8'd1, 8'd1));
		queue_request(pkt_req(8'd2, 8'd1, 8'd200, 8'd0, 8'd0, 8'd4, 8'd1, 8'd1));
		// Train heading to the lower side of node 1: no neighbor there, the aspect holds.
		queue_request(axle_req(1'b1));
		queue_request(pkt_req(8'd2, 8'd1, 8'd200, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1));
		queue_request(pkt_req(8'd2, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
		queue_request(pkt_req(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		queue_request(pkt_req(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
		queue_request(axle_req(1'b0));
		wait_drained();

		run_phase(8'd5, 8'd200, 15, 20, 90, 1'b1);
		run_phase(8'd1, 8'd1, 40, 30, 60, 1'b1);
		run_phase(8'd255, 8'd255, 0, 20, 80, 1'b1);
		run_phase(8'd2, 8'd3, 15, 20, 90, 1'b1);
		run_phase(8'd1, 8'd255, 40, 25, 80, 1'b1);
		run_phase(8'd255, 8'd1, 15, 20, 60, 1'b1);
		run_phase(8'd100, 8'd101, 0, 20, 70, 1'b1);
		run_phase(8'd3, 8'd3, 40, 20, 70, 1'b1);
		run_phase(8'd128, 8'd130, 15, 20, 80, 1'b1);
		// Last stretch runs without stalls; a long run of axles wraps the counter.
		run_phase(8'd4, 8'd7, 0, 20, 60, 1'b0);
		repeat (260) queue_request(axle_req(1'b1));
		queue_request(plan_request(0, 1'b0));
		wait_drained();

		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
